[sv/mfs_pkg.sv]
// Shared types, sizes and codes for the max frequency stack.
package mfs_pkg;

    localparam int CAPACITY   = 64;
    localparam int DISTINCT   = 64;
    localparam int VALUE_BITS = 32;

    localparam int EW     = $clog2(CAPACITY);
    localparam int SW     = $clog2(DISTINCT);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int SCAN_N = (CAPACITY > DISTINCT) ? CAPACITY : DISTINCT;
    localparam int NW     = $clog2(SCAN_N + 1);

    // Request kinds
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Response status codes
    localparam logic [1:0] ST_PUSH  = 2'd0;
    localparam logic [1:0] ST_POP   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic [31:0] pop_value;
        logic [1:0]  status;
    } resp_t;

    // Outcome of one pass over the count table and entry flags
    typedef struct packed {
        logic          match_found;
        logic [SW-1:0] match_slot;
        logic [CW-1:0] match_cnt;
        logic          free_found;
        logic [SW-1:0] free_slot;
        logic          ent_found;
        logic [EW-1:0] ent_idx;
    } scan_res_t;

endpackage

[sv/max_frequency_stack_core.sv]
// Top level of the max frequency stack: control, flags and memories.
//
// Usage:
//   Requests arrive on req (req_valid/req_ready); req_type selects push or
//   pop. Every request gives exactly one response on resp
//   (resp_valid/resp_ready) with a status and, for a pop, the value removed.
//   Requests are handled one at a time.
// Operation:
//   A push and a pop each walk the count table one slot per cycle through
//   its single read port, to find the value's count slot, a free slot and
//   a free entry; max(CAPACITY, DISTINCT) sets the length of the walk. A
//   pop on an empty stack skips the walk and goes straight to the
//   response.
// Reset:
//   Clears all entry, slot and level flags and the top level; the stack is
//   empty and ready right away. Memory contents are not cleared.
// Stalls:
//   The response sits in an output register; the next request is taken
//   while it waits. A finished request holds in its last step until the
//   output register is free.
module max_frequency_stack_core import mfs_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  req_t  req,
    output logic  resp_valid,
    input  logic  resp_ready,
    output resp_t resp
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SCAN = 9'b000000010,
        S_LRD  = 9'b000000100,
        S_PWR  = 9'b000001000,
        S_PRD1 = 9'b000010000,
        S_PRD2 = 9'b000100000,
        S_PUPD = 9'b001000000,
        S_PDEC = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t                state_reg, state_next;
    logic                  op_reg, op_next;
    logic [VALUE_BITS-1:0] key_reg, key_next;
    logic [EW-1:0]         li_reg, li_next;
    logic [EW-1:0]         e_reg, e_next;
    resp_t                 res_reg, res_next;
    logic [CW-1:0]         top_reg, top_next;
    logic [DISTINCT-1:0]   live_reg, live_next;
    logic [CAPACITY-1:0]   used_reg, used_next;
    logic [CAPACITY-1:0]   nonempty_reg, nonempty_next;
    logic                  oval_reg, oval_next;
    resp_t                 out_reg, out_next;

    // Memory ports
    logic                     cnt_we;
    logic [SW-1:0]            cnt_waddr;
    logic [VALUE_BITS+CW-1:0] cnt_wdata, cnt_rdata;
    logic                     ent_we;
    logic [EW-1:0]            ent_waddr, ent_raddr;
    logic [VALUE_BITS+EW-1:0] ent_wdata, ent_rdata;
    logic                     lvl_we;
    logic [EW-1:0]            lvl_waddr, lvl_raddr;
    logic [EW-1:0]            lvl_wdata, lvl_rdata;

    logic          scan_start, scan_done;
    logic [SW-1:0] scan_addr;
    scan_res_t     sres;

    logic          accept, can_out;
    logic [SW-1:0] p_slot;
    logic [CW-1:0] p_old, p_new;
    logic [EW-1:0] pop_below;

    assign req_ready  = (state_reg == S_IDLE);
    assign accept     = req_valid && req_ready;
    assign can_out    = !oval_reg || resp_ready;
    assign resp_valid = oval_reg;
    assign resp       = out_reg;

    // Push target: existing slot or the first free one
    assign p_slot    = sres.match_found ? sres.match_slot : sres.free_slot;
    assign p_old     = sres.match_found ? sres.match_cnt : '0;
    assign p_new     = p_old + CW'(1);
    assign pop_below = ent_rdata[EW-1:0];

    mfs_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .key        (key_next),
        .rd_data    (cnt_rdata),
        .slot_live  (live_reg),
        .entry_used (used_reg),
        .addr       (scan_addr),
        .done       (scan_done),
        .res        (sres)
    );

    mfs_ram #(.WIDTH(VALUE_BITS + CW), .DEPTH(DISTINCT)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (scan_addr),
        .rdata (cnt_rdata)
    );

    mfs_ram #(.WIDTH(VALUE_BITS + EW), .DEPTH(CAPACITY)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    mfs_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_lvl_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .raddr (lvl_raddr),
        .rdata (lvl_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        li_next       = li_reg;
        e_next        = e_reg;
        res_next      = res_reg;
        top_next      = top_reg;
        live_next     = live_reg;
        used_next     = used_reg;
        nonempty_next = nonempty_reg;
        oval_next     = oval_reg && !resp_ready;
        out_next      = out_reg;
        scan_start    = 1'b0;
        cnt_we        = 1'b0;
        cnt_waddr     = p_slot;
        cnt_wdata     = {key_reg, p_new};
        ent_we        = 1'b0;
        ent_waddr     = sres.ent_idx;
        ent_wdata     = {key_reg, sres.ent_idx};
        ent_raddr     = lvl_rdata;
        lvl_we        = 1'b0;
        lvl_waddr     = li_reg;
        lvl_wdata     = sres.ent_idx;
        lvl_raddr     = li_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = req.req_type;
                    key_next = VALUE_BITS'(req.push_value);
                    li_next  = EW'(top_reg - CW'(1));
                    if (req.req_type == REQ_PUSH)
                    begin
                        scan_start = 1'b1;
                        state_next = S_SCAN;
                    end
                    else if (top_reg == '0
                             || !nonempty_reg[EW'(top_reg - CW'(1))])
                    begin
                        res_next   = '{pop_value: '0, status: ST_EMPTY};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PRD1;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    if (op_reg == REQ_POP)
                    begin
                        state_next = S_PDEC;
                    end
                    else if (!(sres.match_found || sres.free_found) || !sres.ent_found)
                    begin
                        res_next   = '{pop_value: '0, status: ST_FULL};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        li_next    = EW'(p_old);
                        state_next = S_LRD;
                    end
                end
            end
            S_LRD:
            begin
                // level top read in flight
                state_next = S_PWR;
            end
            S_PWR:
            begin
                cnt_we    = 1'b1;
                ent_we    = 1'b1;
                ent_wdata = {key_reg, nonempty_reg[li_reg] ? lvl_rdata : sres.ent_idx};
                lvl_we    = 1'b1;
                live_next[p_slot]       = 1'b1;
                used_next[sres.ent_idx] = 1'b1;
                nonempty_next[li_reg]   = 1'b1;
                if (p_new > top_reg)
                begin
                    top_next = p_new;
                end
                res_next   = '{pop_value: '0, status: ST_PUSH};
                state_next = S_DONE;
            end
            S_PRD1:
            begin
                // level top read in flight
                state_next = S_PRD2;
            end
            S_PRD2:
            begin
                e_next     = lvl_rdata;
                state_next = S_PUPD;
            end
            S_PUPD:
            begin
                key_next         = ent_rdata[VALUE_BITS+EW-1:EW];
                used_next[e_reg] = 1'b0;
                if (pop_below == e_reg)
                begin
                    nonempty_next[li_reg] = 1'b0;
                    top_next = top_reg - CW'(1);
                end
                else
                begin
                    lvl_we    = 1'b1;
                    lvl_wdata = pop_below;
                end
                scan_start = 1'b1;
                state_next = S_SCAN;
            end
            S_PDEC:
            begin
                if (sres.match_found)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = sres.match_slot;
                    cnt_wdata = {key_reg, sres.match_cnt - CW'(1)};
                    if (sres.match_cnt == CW'(1))
                    begin
                        live_next[sres.match_slot] = 1'b0;
                    end
                end
                res_next   = '{pop_value: 32'(key_reg), status: ST_POP};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (can_out)
                begin
                    oval_next  = 1'b1;
                    out_next   = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            top_reg      <= '0;
            live_reg     <= '0;
            used_reg     <= '0;
            nonempty_reg <= '0;
            oval_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            top_reg      <= top_next;
            live_reg     <= live_next;
            used_reg     <= used_next;
            nonempty_reg <= nonempty_next;
            oval_reg     <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        li_reg  <= li_next;
        e_reg   <= e_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

endmodule

[sv/mfs_ram.sv]
// Generic simple dual-port RAM with registered read.
module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/mfs_scan.sv]
// Sequential pass over the count table: finds the live slot for a key,
// the first free slot and the first free entry.
module mfs_scan import mfs_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [VALUE_BITS-1:0]    key,
    input  logic [VALUE_BITS+CW-1:0] rd_data,
    input  logic [DISTINCT-1:0]      slot_live,
    input  logic [CAPACITY-1:0]      entry_used,
    output logic [SW-1:0]            addr,
    output logic                     done,
    output scan_res_t                res
);

    logic [NW-1:0] idx_reg, idx_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    scan_res_t     res_reg, res_next;
    logic [NW-1:0] pidx;
    logic [SW-1:0] pslot;

    assign pidx  = idx_reg - NW'(1);
    assign pslot = pidx[SW-1:0];
    assign addr  = idx_reg[SW-1:0];
    assign done  = done_reg;
    assign res   = res_reg;

    // One slot compared and one entry flag checked per cycle
    always_comb
    begin
        idx_next  = idx_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (start)
        begin
            idx_next = '0;
            run_next = 1'b1;
            res_next = '0;
        end
        else if (run_reg)
        begin
            if (idx_reg < NW'(CAPACITY) && !res_reg.ent_found
                && !entry_used[idx_reg[EW-1:0]])
            begin
                res_next.ent_found = 1'b1;
                res_next.ent_idx   = idx_reg[EW-1:0];
            end
            if (idx_reg != '0 && pidx < NW'(DISTINCT))
            begin
                if (slot_live[pslot])
                begin
                    if (!res_reg.match_found && rd_data[VALUE_BITS+CW-1:CW] == key)
                    begin
                        res_next.match_found = 1'b1;
                        res_next.match_slot  = pslot;
                        res_next.match_cnt   = rd_data[CW-1:0];
                    end
                end
                else if (!res_reg.free_found)
                begin
                    res_next.free_found = 1'b1;
                    res_next.free_slot  = pslot;
                end
            end
            if (idx_reg == NW'(SCAN_N))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + NW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule
